// ----- design/sbpm_pkg.sv -----
// shared types, constants and band lookup for the spectrum band peak meter
`default_nettype none

package sbpm_pkg;

   localparam int BANDS     = 8;
   localparam int BAND_W    = 3;
   localparam int BIN_W     = 9;
   localparam int MAG_W     = 16;
   localparam int SUM_W     = 24;
   localparam int LEVEL_W   = 7;
   localparam int VU_W      = 8;
   localparam int VU_ACC_W  = 10;
   localparam int QUO_BITS  = 6;
   localparam int LEVEL_MAX = 64;
   localparam int HALF_BINS = 512;
   localparam int HB_W      = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 16;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDER   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VU_LIMIT  = 2'd3;

   // item kinds carried on tuser
   localparam logic CMD_BIN  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // band edges, inclusive
   localparam logic [BIN_W:0] BAND_LO [BANDS] = '{5, 21, 46, 76, 121, 181, 221, 271};
   localparam logic [BIN_W:0] BAND_HI [BANDS] = '{20, 45, 75, 120, 170, 220, 270, 512};

   typedef logic [LEVEL_W-1:0] level_type;

   typedef struct packed {
      logic      busy;
      logic      done;
      level_type level;
   } div_rsp_type;

   // returns {hit, band}
   function automatic logic [BAND_W:0] band_of(input logic [BIN_W-1:0] bin);
      logic [BAND_W:0] res;
      res = '0;
      for (int b = BANDS - 1; b >= 0; b--) begin
         if ({1'b0, bin} >= BAND_LO[b] && {1'b0, bin} <= BAND_HI[b]) begin
            res = {1'b1, BAND_W'(b)};
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- design/sbpm_divider.sv -----
// iterative compare-subtract unit giving min(dividend / divisor, 64)
`default_nettype none

module sbpm_divider
   import sbpm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SUM_W-1:0]  dividend,
   input  wire logic [MAG_W-1:0]  divisor,
   output div_rsp_type            rsp
);

   localparam int DSR_W  = MAG_W + QUO_BITS;
   localparam int STEP_W = $clog2(QUO_BITS + 1);
   localparam logic [STEP_W-1:0] TOP_STEP = STEP_W'(QUO_BITS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [DSR_W-1:0]    dsr_ff, dsr_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   level_type           level_ff, level_in;

   logic                ge;
   logic [SUM_W-1:0]    diff;

   assign ge   = rem_ff >= SUM_W'(dsr_ff);
   assign diff = rem_ff - SUM_W'(dsr_ff);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      level_in = level_ff;
      if (start) begin
         rem_in  = dividend;
         dsr_in  = {divisor, QUO_BITS'(0)};
         step_in = TOP_STEP;
         quo_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dsr_in  = dsr_ff >> 1;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == TOP_STEP) begin
            // quotient would reach the clamp
            if (ge) begin
               level_in = LEVEL_W'(LEVEL_MAX);
               done_in  = 1'b1;
               busy_in  = 1'b0;
            end
         end else begin
            if (ge) begin
               rem_in = diff;
            end
            quo_in = {quo_ff[QUO_BITS-2:0], ge};
            if (step_ff == '0) begin
               level_in = LEVEL_W'({quo_ff[QUO_BITS-2:0], ge});
               done_in  = 1'b1;
               busy_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      quo_ff   <= quo_in;
      level_ff <= level_in;
   end

   assign rsp = '{busy: busy_ff, done: done_ff, level: level_ff};

endmodule

`default_nettype wire

// ----- design/spectrum_band_peak_meter.sv -----
// spectrum band peak meter top level: accumulators, frame sequencer, result stage
// bins and ticks are taken one per cycle while the sequencer is idle
// a frame end starts 8 band divisions, band by band, on the shared compare-subtract
// unit (the level clamps at 64), then the vu step and the 8 result loads: the block is
// ready again once the last result is loaded (later if rsp stalls)
// synchronous active-high reset: sums, peaks and fade counter to zero, registers
// to divider 7000, threshold 2000, fade speed 30, vu limit 144
`default_nettype none

module spectrum_band_peak_meter
   import sbpm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // input stream
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [31:0]          req_tdata,   // bin_index[8:0], magnitude[24:9]
   input  wire logic                 req_tuser,   // cmd
   input  wire logic                 req_tlast,   // frame_end
   // result stream
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [31:0]               rsp_tdata,   // band[2:0], level[9:3], peak_level[16:10], vu_level[24:17]
   output logic                      rsp_tlast,   // last
   // configuration writes
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   // sequencer states
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DIV_START = 3'd1;
   localparam logic [2:0] S_DIV_WAIT  = 3'd2;
   localparam logic [2:0] S_VU        = 3'd3;
   localparam logic [2:0] S_EMIT      = 3'd4;

   localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(BANDS - 1);

   // configuration registers
   logic [MAG_W-1:0] divider_ff, threshold_ff, fade_speed_ff;
   logic [VU_W-1:0]  vu_limit_ff;

   // frame state
   logic [2:0]         state_ff, state_in;
   logic [BAND_W-1:0]  band_ff, band_in;
   logic [SUM_W-1:0]   band_sum_ff [BANDS];
   logic [SUM_W-1:0]   band_sum_in [BANDS];
   level_type          band_peak_ff [BANDS];
   level_type          band_peak_in [BANDS];
   level_type          level_ff [BANDS];
   level_type          level_in [BANDS];
   logic [MAG_W-1:0]   fade_count_ff, fade_count_in;
   logic [VU_ACC_W-1:0] vu_acc_ff, vu_acc_in;
   logic [VU_W-1:0]    vu_ff, vu_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BAND_W-1:0]  rsp_band_ff, rsp_band_in;
   level_type          rsp_level_ff, rsp_level_in;
   level_type          rsp_peak_ff, rsp_peak_in;
   logic [VU_W-1:0]    rsp_vu_ff, rsp_vu_in;
   logic               rsp_last_ff, rsp_last_in;

   // input fields
   logic [BIN_W-1:0]   in_bin;
   logic [MAG_W-1:0]   in_mag;
   logic               req_accept;
   logic [BAND_W:0]    hit_band;
   logic [BAND_W-1:0]  bidx;
   logic               in_range;
   logic [MAG_W-1:0]   mag_eff;
   logic [SUM_W:0]     sum_add;
   logic [VU_W-1:0]    vu_quarter;

   div_rsp_type        div_rsp;
   logic               div_start;

   assign in_bin     = req_tdata[BIN_W-1:0];
   assign in_mag     = req_tdata[BIN_W+MAG_W-1:BIN_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // band decode, noise gate and saturating add for the incoming bin
   assign hit_band = band_of(in_bin);
   assign bidx     = hit_band[BAND_W-1:0];
   assign in_range = HB_W'(in_bin) < HB_W'(HALF_BINS);
   assign mag_eff  = (in_mag > threshold_ff) ? in_mag : '0;
   assign sum_add  = {1'b0, band_sum_ff[bidx]} + (SUM_W + 1)'(mag_eff);

   assign vu_quarter = VU_W'(vu_acc_ff >> 2);

   // divisions always take band 0; the sums rotate down as each band finishes
   assign div_start = (state_ff == S_DIV_START);

   sbpm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (band_sum_ff[0]),
      .divisor  (divider_ff),
      .rsp      (div_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      band_in       = band_ff;
      fade_count_in = fade_count_ff;
      vu_acc_in     = vu_acc_ff;
      vu_in         = vu_ff;
      band_sum_in   = band_sum_ff;
      band_peak_in  = band_peak_ff;
      level_in      = level_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_band_in   = rsp_band_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_peak_in   = rsp_peak_ff;
      rsp_vu_in     = rsp_vu_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_tuser == CMD_TICK) begin
                  // peak fade on tick
                  if (fade_count_ff >= fade_speed_ff) begin
                     for (int b = 0; b < BANDS; b++) begin
                        if (band_peak_ff[b] != '0) begin
                           band_peak_in[b] = band_peak_ff[b] - LEVEL_W'(1);
                        end
                     end
                     fade_count_in = MAG_W'(1);
                  end else begin
                     fade_count_in = fade_count_ff + MAG_W'(1);
                  end
               end else begin
                  if (hit_band[BAND_W] && in_range) begin
                     band_sum_in[bidx] = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                  end
                  if (req_tlast) begin
                     band_in   = '0;
                     vu_acc_in = '0;
                     state_in  = S_DIV_START;
                  end
               end
            end
         end
         S_DIV_START: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               level_in[band_ff] = div_rsp.level;
               if (div_rsp.level >= band_peak_ff[band_ff]) begin
                  band_peak_in[band_ff] = div_rsp.level;
               end
               vu_acc_in = vu_acc_ff + VU_ACC_W'(div_rsp.level);
               // rotate sums down, clearing the top
               for (int b = 0; b < BANDS - 1; b++) begin
                  band_sum_in[b] = band_sum_ff[b+1];
               end
               band_sum_in[BANDS-1] = '0;
               if (band_ff == LAST_BAND) begin
                  state_in = S_VU;
               end else begin
                  band_in  = band_ff + BAND_W'(1);
                  state_in = S_DIV_START;
               end
            end
         end
         S_VU: begin
            vu_in    = (vu_quarter > vu_limit_ff) ? vu_limit_ff : vu_quarter;
            band_in  = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // load the next result whenever the output register frees up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_band_in  = band_ff;
               rsp_level_in = level_ff[band_ff];
               rsp_peak_in  = band_peak_ff[band_ff];
               rsp_vu_in    = vu_ff;
               rsp_last_in  = (band_ff == LAST_BAND);
               if (band_ff == LAST_BAND) begin
                  state_in = S_IDLE;
               end else begin
                  band_in = band_ff + BAND_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff    <= MAG_W'(7000);
         threshold_ff  <= MAG_W'(2000);
         fade_speed_ff <= MAG_W'(30);
         vu_limit_ff   <= VU_W'(144);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIVIDER:   divider_ff    <= csr_wdata;
            CSR_THRESHOLD: threshold_ff  <= csr_wdata;
            CSR_FADE:      fade_speed_ff <= csr_wdata;
            CSR_VU_LIMIT:  vu_limit_ff   <= csr_wdata[VU_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         band_ff       <= '0;
         fade_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int b = 0; b < BANDS; b++) begin
            band_sum_ff[b]  <= '0;
            band_peak_ff[b] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         band_ff       <= band_in;
         fade_count_ff <= fade_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         band_sum_ff   <= band_sum_in;
         band_peak_ff  <= band_peak_in;
      end
      vu_acc_ff    <= vu_acc_in;
      vu_ff        <= vu_in;
      level_ff     <= level_in;
      rsp_band_ff  <= rsp_band_in;
      rsp_level_ff <= rsp_level_in;
      rsp_peak_ff  <= rsp_peak_in;
      rsp_vu_ff    <= rsp_vu_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'b0, rsp_vu_ff, rsp_peak_ff, rsp_level_ff, rsp_band_ff};

   // no input while the divider is still working
   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_rsp.busy)
      else $error("input ready while division in progress");

   // a division result only arrives while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV_WAIT))
      else $error("division result outside wait state");

   // a held peak never sits below the level it was updated with, and no level passes the clamp
   a_peak_ge_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_peak_ff >= rsp_level_ff) &&
                       (rsp_level_ff <= LEVEL_W'(LEVEL_MAX)))
      else $error("result level above peak or clamp");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// self-checking testbench for the spectrum band peak meter
`timescale 1ns / 1ps

module testbench
   import sbpm_pkg::*;
;

   // one input transaction: bin or tick
   typedef struct {
      logic             cmd;
      logic [BIN_W-1:0] bin;
      logic [MAG_W-1:0] mag;
      logic             fend;
   } spectrum_item_type;

   // one band result
   typedef struct {
      logic [BAND_W-1:0]  band;
      level_type          level;
      level_type          peak;
      logic [VU_W-1:0]    vu;
      logic               is_last;
   } band_report_type;

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 120;
   localparam int PRESSURE_CYCLES = 400;

   // inclusive bin ranges of the eight bands; the gap 171-180 belongs to none
   localparam int EDGE_LO [8] = '{5, 21, 46, 76, 121, 181, 221, 271};
   localparam int EDGE_HI [8] = '{20, 45, 75, 120, 170, 220, 270, 512};

   // bins on or next to a band edge, favored by the random traffic
   localparam int EDGE_BINS [19] = '{4, 5, 20, 21, 45, 46, 75, 76, 120, 121, 170, 171,
                                     180, 181, 220, 221, 270, 271, 511};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata = '0;   // bin_index[8:0], magnitude[24:9]
   logic                 req_tuser = 1'b0; // cmd
   logic                 req_tlast = 1'b0; // frame_end
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;        // band[2:0], level[9:3], peak_level[16:10], vu_level[24:17]
   logic                 rsp_tlast;        // last
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   spectrum_band_peak_meter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // stimulus waiting for the driver, and band results still owed by the block
   spectrum_item_type items [$];
   band_report_type   reports_due [$];

   // predictor copy of the registers, reset values
   logic [15:0] div_reg     = 16'd7000;
   logic [15:0] noise_floor = 16'd2000;
   logic [15:0] fade_period = 16'd30;
   logic [7:0]  vu_cap      = 8'd144;

   // predictor copy of the block state
   logic [SUM_W-1:0] band_sum  [BANDS];
   level_type        band_peak [BANDS];
   logic [15:0]      fade_count;

   int items_queued = 0;
   int items_taken  = 0;
   int bins_taken   = 0;
   int ticks_taken  = 0;
   int frames_closed = 0;
   int reports_checked = 0;
   int mismatches = 0;
   int config_writes = 0;

   // idling control shared between the sequence and the two bus sides
   logic quiet   = 1'b0;
   logic squeeze = 1'b0;

   initial begin
      for (int i = 0; i < BANDS; i++) begin
         band_sum[i]  = '0;
         band_peak[i] = '0;
      end
      fade_count = '0;
   end

   // band number of a bin, -1 when the bin feeds no band
   function automatic int band_for_bin(input logic [BIN_W-1:0] bin);
      int b;
      for (b = 0; b < 8; b++) begin
         if (int'(bin) >= EDGE_LO[b] && int'(bin) <= EDGE_HI[b]) return b;
      end
      return -1;
   endfunction

   // advance the meter by one accepted transaction and queue the band results it owes
   task automatic update_meter(input spectrum_item_type it);
      logic [MAG_W-1:0] m;
      logic [SUM_W:0]   s;
      int               b;
      int               i;
      int unsigned      q;
      int unsigned      vu;
      int unsigned      lv [BANDS];
      band_report_type  r;
      if (it.cmd == CMD_TICK) begin
         ticks_taken++;
         // peaks fall by one once the fade counter has reached the fade period
         if (fade_count >= fade_period) begin
            for (i = 0; i < BANDS; i++) begin
               if (band_peak[i] != '0) band_peak[i] = band_peak[i] - LEVEL_W'(1);
            end
            fade_count = '0;
         end
         fade_count = fade_count + 16'd1;
         return;
      end
      bins_taken++;
      // at or below the noise floor a bin counts as silence
      m = (it.mag <= noise_floor) ? '0 : it.mag;
      b = band_for_bin(it.bin);
      if (b >= 0) begin
         s = {1'b0, band_sum[b]} + (SUM_W + 1)'(m);
         band_sum[b] = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
      end
      if (!it.fend) return;
      frames_closed++;
      vu = 0;
      for (i = 0; i < BANDS; i++) begin
         // a zero divider reads as an all-ones quotient, so it clamps as well
         q = (div_reg == '0) ? LEVEL_MAX : 32'(band_sum[i] / div_reg);
         if (q > LEVEL_MAX) q = LEVEL_MAX;
         lv[i] = q;
         if (q >= band_peak[i]) band_peak[i] = q[LEVEL_W-1:0];
         vu += q;
      end
      vu = vu / 4;
      if (vu > 32'(vu_cap)) vu = 32'(vu_cap);
      for (i = 0; i < BANDS; i++) begin
         r.band    = i[BAND_W-1:0];
         r.level   = lv[i][LEVEL_W-1:0];
         r.peak    = band_peak[i];
         r.vu      = vu[VU_W-1:0];
         r.is_last = (i == BANDS - 1);
         reports_due.push_back(r);
         band_sum[i] = '0;
      end
   endtask

   // ---------------------------------------------------------------------
   // driver: offers queued items, random gaps between transactions
   // ---------------------------------------------------------------------
   spectrum_item_type cur_item;
   int                gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            update_meter(cur_item);
            items_taken++;
         end
         // only move on once the current transaction has gone through
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (items.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
               // random gap before the next transaction
               gap_left   <= $urandom_range(0, 15);
               req_tvalid <= 1'b0;
            end else if (items.size() != 0) begin
               cur_item    = items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {7'd0, cur_item.mag, cur_item.bin};
               req_tuser  <= cur_item.cmd;
               req_tlast  <= cur_item.fend;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver ready: random stalls, plus one long hold-off to back up the block
   // ---------------------------------------------------------------------
   int   stall_left;
   int   hold_left;
   logic squeeze_taken;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready    <= 1'b0;
         stall_left    <= 0;
         hold_left     <= 0;
         squeeze_taken <= 1'b0;
      end else if (squeeze && !squeeze_taken) begin
         squeeze_taken <= 1'b1;
         hold_left     <= PRESSURE_CYCLES;
         rsp_tready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= (hold_left == 1);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: every result transaction against the oldest owed band result
   // ---------------------------------------------------------------------
   band_report_type exp_r;
   band_report_type got_r;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_r.band    = rsp_tdata[2:0];
         got_r.level   = rsp_tdata[9:3];
         got_r.peak    = rsp_tdata[16:10];
         got_r.vu      = rsp_tdata[24:17];
         got_r.is_last = rsp_tlast;
         if (reports_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result band %0d level %0d peak %0d vu %0d last %0d",
                        $realtime, got_r.band, got_r.level, got_r.peak, got_r.vu,
                        got_r.is_last);
         end else begin
            exp_r = reports_due.pop_front();
            reports_checked++;
            if (got_r.band != exp_r.band || got_r.level != exp_r.level ||
                got_r.peak != exp_r.peak || got_r.vu != exp_r.vu ||
                got_r.is_last != exp_r.is_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: band result mismatch, expected band %0d level %0d peak %0d ",
                            "vu %0d last %0d, got band %0d level %0d peak %0d vu %0d last %0d"},
                           $realtime, exp_r.band, exp_r.level, exp_r.peak, exp_r.vu,
                           exp_r.is_last, got_r.band, got_r.level, got_r.peak, got_r.vu,
                           got_r.is_last);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: cycles with work outstanding but no transaction on either side
   // ---------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else if (req_tvalid || items_taken != items_queued || reports_due.size() != 0)
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d band results owed",
                     STALL_LIMIT, reports_due.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // sequence helpers
   // ---------------------------------------------------------------------
   task automatic push_item(input logic cmd, input int bin, input int mag, input logic fend);
      spectrum_item_type it;
      it.cmd  = cmd;
      it.bin  = bin[BIN_W-1:0];
      it.mag  = mag[MAG_W-1:0];
      it.fend = fend;
      items.push_back(it);
      items_queued++;
   endtask

   // registers change only here, with the block idle, so the predictor follows at once
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_DIVIDER:   div_reg     = val;
         CSR_THRESHOLD: noise_floor = val;
         CSR_FADE:      fade_period = val;
         CSR_VU_LIMIT:  vu_cap      = val[7:0];
         default: ;
      endcase
      config_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all(input int dv, input int th, input int fd, input int vl);
      write_reg(CSR_DIVIDER, dv[15:0]);
      write_reg(CSR_THRESHOLD, th[15:0]);
      write_reg(CSR_FADE, fd[15:0]);
      write_reg(CSR_VU_LIMIT, {8'd0, vl[7:0]});
   endtask

   // wait until every item is taken and every band result is back, then let the
   // frame pass wind down before touching registers
   task automatic settle();
      while (items_taken != items_queued || reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random frames of bins with ticks mixed in
   task automatic queue_traffic(input int count);
      int n;
      int len;
      int k;
      int bin;
      int mag;
      n = 0;
      while (n < count) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
         for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 7) == 0) begin
               // tick with junk in the unused fields, a stray frame mark among them
               push_item(CMD_TICK, $urandom_range(0, 511), $urandom_range(0, 65535),
                         $urandom_range(0, 1));
               n++;
            end
            if ($urandom_range(0, 3) == 0) bin = EDGE_BINS[$urandom_range(0, 18)];
            else bin = $urandom_range(0, 511);
            case ($urandom_range(0, 7))
               0:       mag = (noise_floor + $urandom_range(0, 1)) & 16'hFFFF;
               1:       mag = $urandom_range(0, 65535);
               default: mag = $urandom & ((1 << $urandom_range(1, 16)) - 1);
            endcase
            push_item(CMD_BIN, bin, mag, k == len - 1);
            n++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: band edges, the threshold boundary and the gap
      push_item(CMD_BIN, 4, 65535, 1'b0);       // below the first band
      push_item(CMD_BIN, 5, 65535, 1'b0);
      push_item(CMD_BIN, 20, 2000, 1'b0);       // equal to threshold, counts as zero
      push_item(CMD_BIN, 21, 2001, 1'b0);       // just above threshold
      push_item(CMD_BIN, 45, 65535, 1'b0);
      push_item(CMD_BIN, 170, 65535, 1'b0);
      push_item(CMD_BIN, 171, 65535, 1'b0);     // gap between bands four and five
      push_item(CMD_BIN, 180, 65535, 1'b0);
      push_item(CMD_BIN, 181, 65535, 1'b0);
      push_item(CMD_BIN, 511, 65535, 1'b0);
      push_item(CMD_BIN, 0, 0, 1'b1);           // frame closed on an ignored bin
      push_item(CMD_TICK, 511, 65535, 1'b1);    // tick ignores its data and frame mark
      push_item(CMD_BIN, 176, 65535, 1'b1);     // empty frame, peaks held
      push_item(CMD_TICK, 0, 0, 1'b0);
      settle();

      // every bin counts, levels clamp, peaks fade on each tick
      write_all(1, 0, 0, 255);
      push_item(CMD_BIN, 100, 1, 1'b0);
      push_item(CMD_BIN, 300, 65535, 1'b1);
      push_item(CMD_TICK, 0, 0, 1'b0);
      push_item(CMD_TICK, 0, 0, 1'b0);
      push_item(CMD_TICK, 0, 0, 1'b0);
      push_item(CMD_BIN, 0, 0, 1'b1);
      settle();

      // zero divider saturates every level, zero vu limit clamps vu to nothing
      write_reg(CSR_DIVIDER, 16'd0);
      write_reg(CSR_VU_LIMIT, 16'd0);
      push_item(CMD_BIN, 10, 5, 1'b1);
      push_item(CMD_TICK, 0, 0, 1'b0);
      push_item(CMD_BIN, 511, 1, 1'b1);
      settle();

      // random phases under several register settings
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: write_all(65535, 0, 65535, 1);
            1: write_all($urandom_range(1, 1500), $urandom_range(0, 3000),
                         $urandom_range(0, 3), $urandom_range(1, 255));
            4: write_all($urandom_range(1, 20000), 65535, $urandom_range(0, 40), 255);
            5: write_all($urandom_range(1, 5000), $urandom_range(0, 2000),
                         $urandom_range(0, 10), $urandom_range(1, 255));
            default: write_all($urandom_range(1, 20000), $urandom_range(0, 6000),
                               $urandom_range(0, 40), $urandom_range(0, 255));
         endcase
         queue_traffic(62);
         // long receiver hold-off while frames keep coming
         if (p == 1) squeeze <= 1'b1;
         // the closing stretch runs at full rate on both sides
         if (p == 5) quiet <= 1'b1;
         settle();
      end

      $display("run covered %0d transactions in: %0d bins, %0d ticks, %0d frames closed",
               items_taken, bins_taken, ticks_taken, frames_closed);
      $display("%0d band results checked under %0d register writes, %0d mismatches",
               reports_checked, config_writes, mismatches);
      if (mismatches == 0 && reports_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- spectrum_band_peak_meter.f -----
design/sbpm_pkg.sv
design/sbpm_divider.sv
design/spectrum_band_peak_meter.sv
dv/testbench.sv
